### hdl/varint_chunk_map_parser_unit_defines.svh
// assertion macros for the chunk map parser unit
// used by the parser and output queue modules; expects clk and arst_n in scope
`ifndef VARINT_CHUNK_MAP_PARSER_UNIT_DEFINES_SVH
`define VARINT_CHUNK_MAP_PARSER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge outside reset
`define VCMP_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// condition in this cycle implies a consequence in the same cycle
`define VCMP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition in this cycle implies a consequence in the next cycle
`define VCMP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define VCMP_ASSERT_ALWAYS(lbl, cond, msg)
`define VCMP_ASSERT_NOW(lbl, ante, cons, msg)
`define VCMP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hdl/vcmp_pkg.sv
// shared types and codes of the chunk map parser unit
// no dependencies; imported by every module of the block
package vcmp_pkg;

	localparam int CODE_W  = 16;
	localparam int DEF_W   = 12;
	localparam int VALUE_W = 32;
	localparam int KIND_W  = 3;
	localparam int INDEX_W = 3;

	// result kinds
	localparam logic [KIND_W-1:0] K_CHIPSET = 3'd0;
	localparam logic [KIND_W-1:0] K_WIDTH   = 3'd1;
	localparam logic [KIND_W-1:0] K_HEIGHT  = 3'd2;
	localparam logic [KIND_W-1:0] K_LOWER   = 3'd3;
	localparam logic [KIND_W-1:0] K_UPPER   = 3'd4;
	localparam logic [KIND_W-1:0] K_END     = 3'd5;

	// configuration register indexes
	localparam logic [INDEX_W-1:0] REG_CHIPSET  = 3'd0;
	localparam logic [INDEX_W-1:0] REG_WIDTH    = 3'd1;
	localparam logic [INDEX_W-1:0] REG_HEIGHT   = 3'd2;
	localparam logic [INDEX_W-1:0] REG_LOWER    = 3'd3;
	localparam logic [INDEX_W-1:0] REG_UPPER    = 3'd4;
	localparam logic [INDEX_W-1:0] REG_END      = 3'd5;
	localparam logic [INDEX_W-1:0] REG_DEF_WID  = 3'd6;
	localparam logic [INDEX_W-1:0] REG_DEF_HGT  = 3'd7;

	// register reset values
	localparam logic [CODE_W-1:0] RST_CHIPSET = 16'd1;
	localparam logic [CODE_W-1:0] RST_WIDTH   = 16'd2;
	localparam logic [CODE_W-1:0] RST_HEIGHT  = 16'd3;
	localparam logic [CODE_W-1:0] RST_LOWER   = 16'd71;
	localparam logic [CODE_W-1:0] RST_UPPER   = 16'd72;
	localparam logic [CODE_W-1:0] RST_END     = 16'd0;
	localparam logic [DEF_W-1:0]  RST_DEF_WID = 12'd20;
	localparam logic [DEF_W-1:0]  RST_DEF_HGT = 12'd15;

	localparam logic [7:0] CONT_MASK = 8'h80;
	localparam logic [7:0] DATA_MASK = 8'h7f;

	typedef struct packed {
		logic [CODE_W-1:0] chipset_code;
		logic [CODE_W-1:0] width_code;
		logic [CODE_W-1:0] height_code;
		logic [CODE_W-1:0] lower_layer_code;
		logic [CODE_W-1:0] upper_layer_code;
		logic [CODE_W-1:0] end_code;
		logic [DEF_W-1:0]  default_width;
		logic [DEF_W-1:0]  default_height;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic               layer_last;
	} res_t;

endpackage

### hdl/vcmp_parse.sv
// per-byte parser: state registers and the next-state logic for one byte
// depends on vcmp_pkg and the assertion macro header
`include "varint_chunk_map_parser_unit_defines.svh"

module vcmp_parse import vcmp_pkg::*; #(
	parameter int TILE_BYTES = 2,
	parameter int SIDE_BITS  = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       advance,
	input  logic [7:0] data_byte,
	input  logic       first,
	output logic       res_valid,
	output res_t       res
);

	localparam int PROD_W = 2 * SIDE_BITS + 4;
	localparam logic [SIDE_BITS-1:0] SIDE_MAX = '1;

	localparam logic [2:0] M_HDR_LEN  = 3'd0;
	localparam logic [2:0] M_HDR_SKIP = 3'd1;
	localparam logic [2:0] M_TYPE     = 3'd2;
	localparam logic [2:0] M_SIZE     = 3'd3;
	localparam logic [2:0] M_VALUE    = 3'd4;
	localparam logic [2:0] M_TILES    = 3'd5;
	localparam logic [2:0] M_SKIP     = 3'd6;
	localparam logic [2:0] M_DONE     = 3'd7;

	function automatic logic [SIDE_BITS-1:0] sat_side(input logic [VALUE_W-1:0] v);
		if (v > VALUE_W'(SIDE_MAX))
			return SIDE_MAX;
		else
			return SIDE_BITS'(v);
	endfunction

	logic [2:0]             mode_q, mode_c, mode_n;
	logic [VALUE_W-1:0]     acc_q, acc_c, acc_n, acc_sh;
	logic [VALUE_W-1:0]     cnt_q, cnt_c, cnt_n, cnt_dec;
	logic [VALUE_W-1:0]     type_q, type_c, type_n;
	logic [SIDE_BITS-1:0]   wid_q, wid_c, wid_n;
	logic [SIDE_BITS-1:0]   hgt_q, hgt_c, hgt_n;
	logic                   lseen_q, lseen_c, lseen_n;
	logic                   useen_q, useen_c, useen_n;
	logic [KIND_W-1:0]      pend_q, pend_c, pend_n;
	logic [PROD_W-1:0]      prod_q;
	logic [VALUE_W-1:0]     layer_cnt;
	logic                   vend;
	logic                   up_hit, lo_hit;

	// tile count is registered from the side registers; a layer size is
	// never decoded in the cycle right after a side changes
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(wid_q) * PROD_W'(hgt_q) * PROD_W'(TILE_BYTES);
	end

	assign layer_cnt = (64'(prod_q) > 64'hffff_ffff) ? '1 : VALUE_W'(prod_q);

	always_comb begin
		// restart byte sees the start-of-file state, with sides from the cfg defaults
		if (first) begin
			mode_c  = M_HDR_LEN;
			acc_c   = '0;
			cnt_c   = '0;
			type_c  = '0;
			wid_c   = sat_side(VALUE_W'(cfg.default_width));
			hgt_c   = sat_side(VALUE_W'(cfg.default_height));
			lseen_c = 1'b0;
			useen_c = 1'b0;
			pend_c  = K_CHIPSET;
		end else begin
			mode_c  = mode_q;
			acc_c   = acc_q;
			cnt_c   = cnt_q;
			type_c  = type_q;
			wid_c   = wid_q;
			hgt_c   = hgt_q;
			lseen_c = lseen_q;
			useen_c = useen_q;
			pend_c  = pend_q;
		end
	end

	always_comb begin
		acc_sh   = {acc_c[VALUE_W-8:0], data_byte[6:0] & DATA_MASK[6:0]};
		vend     = (data_byte & CONT_MASK) == 8'h00;
		cnt_dec  = cnt_c - VALUE_W'(1);
		up_hit   = type_c == VALUE_W'(cfg.upper_layer_code);
		lo_hit   = type_c == VALUE_W'(cfg.lower_layer_code);

		mode_n    = mode_c;
		acc_n     = acc_c;
		cnt_n     = cnt_c;
		type_n    = type_c;
		wid_n     = wid_c;
		hgt_n     = hgt_c;
		lseen_n   = lseen_c;
		useen_n   = useen_c;
		pend_n    = pend_c;
		res_valid = 1'b0;
		res       = '{kind: K_END, value: '0, layer_last: 1'b0};

		unique case (mode_c)
			M_HDR_LEN: begin
				acc_n = acc_sh;
				if (vend) begin
					acc_n  = '0;
					cnt_n  = acc_sh;
					mode_n = (acc_sh != '0) ? M_HDR_SKIP : M_TYPE;
				end
			end
			M_HDR_SKIP, M_SKIP: begin
				cnt_n = cnt_dec;
				if (cnt_dec == '0)
					mode_n = M_TYPE;
			end
			M_TYPE: begin
				acc_n = acc_sh;
				if (vend) begin
					acc_n  = '0;
					type_n = acc_sh;
					if (acc_sh == VALUE_W'(cfg.end_code)) begin
						mode_n    = M_DONE;
						res_valid = 1'b1;
					end else begin
						mode_n = M_SIZE;
					end
				end
			end
			M_SIZE: begin
				acc_n = acc_sh;
				if (vend) begin
					acc_n = '0;
					if (type_c == VALUE_W'(cfg.chipset_code)) begin
						pend_n = K_CHIPSET;
						mode_n = M_VALUE;
					end else if (type_c == VALUE_W'(cfg.width_code)) begin
						pend_n = K_WIDTH;
						mode_n = M_VALUE;
					end else if (type_c == VALUE_W'(cfg.height_code)) begin
						pend_n = K_HEIGHT;
						mode_n = M_VALUE;
					end else if ((up_hit && !useen_c) || (!up_hit && lo_hit && !lseen_c)) begin
						if (up_hit) begin
							useen_n = 1'b1;
							pend_n  = K_UPPER;
						end else begin
							lseen_n = 1'b1;
							pend_n  = K_LOWER;
						end
						cnt_n  = layer_cnt;
						mode_n = (layer_cnt != '0) ? M_TILES : M_TYPE;
					end else begin
						// unknown or repeated chunk: skip the body
						cnt_n  = acc_sh;
						mode_n = (acc_sh != '0) ? M_SKIP : M_TYPE;
					end
				end
			end
			M_VALUE: begin
				acc_n = acc_sh;
				if (vend) begin
					acc_n = '0;
					if (pend_c == K_WIDTH)
						wid_n = sat_side(acc_sh);
					else if (pend_c == K_HEIGHT)
						hgt_n = sat_side(acc_sh);
					mode_n    = M_TYPE;
					res_valid = 1'b1;
					res       = '{kind: pend_c, value: acc_sh, layer_last: 1'b0};
				end
			end
			M_TILES: begin
				cnt_n = cnt_dec;
				if (cnt_dec == '0)
					mode_n = M_TYPE;
				res_valid = 1'b1;
				res       = '{kind: pend_c, value: VALUE_W'(data_byte),
					layer_last: cnt_dec == '0};
			end
			M_DONE: begin
				// bytes are dropped until a restart
			end
			default: begin
			end
		endcase

		if (!advance)
			res_valid = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_HDR_LEN;
			acc_q   <= '0;
			cnt_q   <= '0;
			type_q  <= '0;
			wid_q   <= sat_side(VALUE_W'(RST_DEF_WID));
			hgt_q   <= sat_side(VALUE_W'(RST_DEF_HGT));
			lseen_q <= 1'b0;
			useen_q <= 1'b0;
			pend_q  <= K_CHIPSET;
		end else if (advance) begin
			mode_q  <= mode_n;
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
			type_q  <= type_n;
			wid_q   <= wid_n;
			hgt_q   <= hgt_n;
			lseen_q <= lseen_n;
			useen_q <= useen_n;
			pend_q  <= pend_n;
		end
	end

	`VCMP_ASSERT_NOW(a_last_only_tiles, res_valid && res.layer_last,
		res.kind == K_LOWER || res.kind == K_UPPER, "layer_last on a non-tile result")
	`VCMP_ASSERT_NOW(a_done_silent, mode_q == M_DONE && !first, !res_valid,
		"result after end code")
	`VCMP_ASSERT_NOW(a_count_live, mode_q == M_TILES || mode_q == M_SKIP || mode_q == M_HDR_SKIP,
		cnt_q != '0, "zero countdown in a counting mode")

endmodule

### hdl/vcmp_out_q.sv
// two-word output queue that decouples the parser from the receiver
// depends on vcmp_pkg and the assertion macro header
`include "varint_chunk_map_parser_unit_defines.svh"

module vcmp_out_q import vcmp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_res,
	output logic full,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	res_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != 2'd0;
	assign full      = count_q == 2'd2;
	assign out_res   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`VCMP_ASSERT_ALWAYS(a_no_overflow, !(push && full), "push into a full queue")
	`VCMP_ASSERT_ALWAYS(a_ptr_match, (wr_ptr_q ^ rd_ptr_q) == (count_q == 2'd1),
		"pointers disagree with fill count")
	`VCMP_ASSERT_NEXT(a_drain, count_q == 2'd1 && pop && !push, !out_valid,
		"queue not empty after last word left")

endmodule

### hdl/varint_chunk_map_parser_unit.sv
// Chunk map parser: takes a map file one byte per word on the slave stream
// (s_tdata = byte, s_tuser = first-byte flag) and returns decoded chunk values
// and tile bytes on the master stream (m_tuser = kind, m_tdata = value,
// m_tlast = last tile byte of a layer). Bytes that yield no result (header,
// varint continuation, skipped bodies, anything after the end code) are
// consumed silently. Chunk type codes and default sides are to be set on the cfg
// write port only while the block is idle; the block itself does not enforce it.
// Throughput: one byte per cycle while the output queue has room; every byte's
// state update is a single pass of logic between the input register and the
// two-word output queue. An accepted byte waits in the input register, is
// parsed once the queue has room, and its result is queued for m_tvalid.
// Reset clears the parser to the start of a file with default sides and loads
// the register reset values; a byte flagged first restarts to cfg default sides.
// When the receiver stalls, the queue holds two results, the input register
// holds the next byte, and s_tready drops until space frees up.
// depends on vcmp_pkg, vcmp_parse and vcmp_out_q
module varint_chunk_map_parser_unit import vcmp_pkg::*; #(
	parameter int TILE_BYTES = 2,
	parameter int SIDE_BITS  = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,    // [7:0] data_byte
	input  logic               s_tuser,    // [0] first
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [VALUE_W-1:0] m_tdata,    // [31:0] value
	output logic [KIND_W-1:0]  m_tuser,    // [2:0] kind
	output logic               m_tlast,
	input  logic               cfg_we,
	input  logic [INDEX_W-1:0] cfg_index,
	input  logic [CODE_W-1:0]  cfg_data
);

	cfg_t       cfg_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       advance;
	logic       q_full;
	logic       res_valid;
	res_t       res;
	res_t       out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{chipset_code: RST_CHIPSET, width_code: RST_WIDTH,
				height_code: RST_HEIGHT, lower_layer_code: RST_LOWER,
				upper_layer_code: RST_UPPER, end_code: RST_END,
				default_width: RST_DEF_WID, default_height: RST_DEF_HGT};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CHIPSET: cfg_q.chipset_code     <= cfg_data;
				REG_WIDTH:   cfg_q.width_code       <= cfg_data;
				REG_HEIGHT:  cfg_q.height_code      <= cfg_data;
				REG_LOWER:   cfg_q.lower_layer_code <= cfg_data;
				REG_UPPER:   cfg_q.upper_layer_code <= cfg_data;
				REG_END:     cfg_q.end_code         <= cfg_data;
				REG_DEF_WID: cfg_q.default_width    <= cfg_data[DEF_W-1:0];
				REG_DEF_HGT: cfg_q.default_height   <= cfg_data[DEF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// the held byte moves on whenever the queue has room
	assign advance  = valid_s1 && !q_full;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
		end
	end

	vcmp_parse #(
		.TILE_BYTES(TILE_BYTES),
		.SIDE_BITS (SIDE_BITS)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.advance  (advance),
		.data_byte(byte_s1),
		.first    (first_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	vcmp_out_q u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_res (res),
		.full     (q_full),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res)
	);

	assign m_tdata = out_res.value;
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.layer_last;

endmodule

### dv/tb_varint_chunk_map_parser_unit.sv
// testbench for the chunk map parser unit: drives well-formed map files, cut-off
// files and stray bytes, predicts every result word and checks it on the fly
// depends on vcmp_pkg and varint_chunk_map_parser_unit
import vcmp_pkg::*;

typedef enum logic [2:0] {
	PM_HDR_LEN, PM_HDR_SKIP, PM_TYPE, PM_SIZE, PM_VALUE, PM_TILES, PM_SKIP, PM_DONE
} parse_mode_e;

typedef enum int {R_END, R_CHIPSET, R_WIDTH, R_HEIGHT, R_UPPER, R_LOWER, R_OTHER} chunk_role_e;

class map_scoreboard #(int TILE_BYTES = 2, int SIDE_BITS = 12);
	localparam logic [31:0] SIDE_MAX = (32'd1 << SIDE_BITS) - 1;

	cfg_t                  cfg;
	parse_mode_e           mode;
	logic [31:0]           acc;
	logic [31:0]           countdown;
	logic [31:0]           chunk_id;
	logic [SIDE_BITS-1:0]  map_wid;
	logic [SIDE_BITS-1:0]  map_hgt;
	bit                    lower_done;
	bit                    upper_done;
	logic [KIND_W-1:0]     pend_kind;
	res_t                  due_results[$];
	int                    n_errors;
	int                    n_bytes;
	int                    n_results;
	int                    n_tiles;
	int                    n_ends;

	function new();
		cfg.chipset_code     = RST_CHIPSET;
		cfg.width_code       = RST_WIDTH;
		cfg.height_code      = RST_HEIGHT;
		cfg.lower_layer_code = RST_LOWER;
		cfg.upper_layer_code = RST_UPPER;
		cfg.end_code         = RST_END;
		cfg.default_width    = RST_DEF_WID;
		cfg.default_height   = RST_DEF_HGT;
		restart();
	endfunction

	function void write_cfg(logic [INDEX_W-1:0] idx, logic [CODE_W-1:0] val);
		case (idx)
			REG_CHIPSET: cfg.chipset_code = val;
			REG_WIDTH:   cfg.width_code = val;
			REG_HEIGHT:  cfg.height_code = val;
			REG_LOWER:   cfg.lower_layer_code = val;
			REG_UPPER:   cfg.upper_layer_code = val;
			REG_END:     cfg.end_code = val;
			REG_DEF_WID: cfg.default_width = val[DEF_W-1:0];
			REG_DEF_HGT: cfg.default_height = val[DEF_W-1:0];
			default: ;
		endcase
	endfunction

	function logic [SIDE_BITS-1:0] clamp_side(logic [31:0] v);
		return (v > SIDE_MAX) ? SIDE_BITS'(SIDE_MAX) : SIDE_BITS'(v);
	endfunction

	function void restart();
		mode       = PM_HDR_LEN;
		acc        = '0;
		countdown  = '0;
		chunk_id   = '0;
		map_wid    = clamp_side(32'(cfg.default_width));
		map_hgt    = clamp_side(32'(cfg.default_height));
		lower_done = 1'b0;
		upper_done = 1'b0;
		pend_kind  = K_CHIPSET;
	endfunction

	// codes are matched in priority order, first hit wins
	function chunk_role_e role_of(logic [31:0] t);
		if (t == 32'(cfg.end_code))
			return R_END;
		if (t == 32'(cfg.chipset_code))
			return R_CHIPSET;
		if (t == 32'(cfg.width_code))
			return R_WIDTH;
		if (t == 32'(cfg.height_code))
			return R_HEIGHT;
		if (t == 32'(cfg.upper_layer_code))
			return R_UPPER;
		if (t == 32'(cfg.lower_layer_code))
			return R_LOWER;
		return R_OTHER;
	endfunction

	// shifts one 7-bit group in; returns 1 when the number is complete
	function bit take_group(logic [7:0] b, output logic [31:0] v);
		acc = (acc << 7) | 32'(b & DATA_MASK);
		v = acc;
		if ((b & CONT_MASK) != 0)
			return 1'b0;
		acc = '0;
		return 1'b1;
	endfunction

	function void predict(logic [KIND_W-1:0] k, logic [31:0] v, logic l);
		res_t r;
		r.kind       = k;
		r.value      = v;
		r.layer_last = l;
		due_results.push_back(r);
	endfunction

	function void skip_body(logic [31:0] sz);
		countdown = sz;
		mode = (sz != 0) ? PM_SKIP : PM_TYPE;
	endfunction

	function void start_layer(logic [KIND_W-1:0] k);
		logic [63:0] cells;
		cells = 64'(map_wid) * 64'(map_hgt) * TILE_BYTES;
		pend_kind = k;
		countdown = (cells > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cells[31:0];
		mode = (countdown != 0) ? PM_TILES : PM_TYPE;
	endfunction

	function void after_size(logic [31:0] sz);
		case (role_of(chunk_id))
			R_CHIPSET: begin
				pend_kind = K_CHIPSET;
				mode = PM_VALUE;
			end
			R_WIDTH: begin
				pend_kind = K_WIDTH;
				mode = PM_VALUE;
			end
			R_HEIGHT: begin
				pend_kind = K_HEIGHT;
				mode = PM_VALUE;
			end
			R_UPPER: begin
				if (!upper_done) begin
					upper_done = 1'b1;
					start_layer(K_UPPER);
				end else
					skip_body(sz);
			end
			R_LOWER: begin
				if (!lower_done) begin
					lower_done = 1'b1;
					start_layer(K_LOWER);
				end else
					skip_body(sz);
			end
			default: skip_body(sz);
		endcase
	endfunction

	// one accepted input word
	function void take_byte(logic [7:0] b, logic first);
		logic [31:0] v;
		n_bytes++;
		if (first)
			restart();
		case (mode)
			PM_HDR_LEN: begin
				if (take_group(b, v))
					skip_body(v);
				if (mode == PM_SKIP)
					mode = PM_HDR_SKIP;
			end
			PM_HDR_SKIP, PM_SKIP: begin
				countdown--;
				if (countdown == 0)
					mode = PM_TYPE;
			end
			PM_TYPE: begin
				if (take_group(b, v)) begin
					chunk_id = v;
					if (v == 32'(cfg.end_code)) begin
						mode = PM_DONE;
						predict(K_END, '0, 1'b0);
					end else
						mode = PM_SIZE;
				end
			end
			PM_SIZE: begin
				if (take_group(b, v))
					after_size(v);
			end
			PM_VALUE: begin
				if (take_group(b, v)) begin
					if (pend_kind == K_WIDTH)
						map_wid = clamp_side(v);
					else if (pend_kind == K_HEIGHT)
						map_hgt = clamp_side(v);
					mode = PM_TYPE;
					predict(pend_kind, v, 1'b0);
				end
			end
			PM_TILES: begin
				countdown--;
				if (countdown == 0)
					mode = PM_TYPE;
				predict(pend_kind, 32'(b), countdown == 0);
			end
			default: ;
		endcase
	endfunction

	function void mismatch(string field, logic [31:0] want, logic [31:0] got);
		n_errors++;
		$error("%s mismatch: expected %0h, actual %0h", field, want, got);
	endfunction

	function void check_result(logic [KIND_W-1:0] kind, logic [31:0] value, logic last);
		res_t want;
		if (due_results.size() == 0) begin
			n_errors++;
			$error("result word with nothing pending: kind %0d value %0h", kind, value);
			return;
		end
		want = due_results.pop_front();
		n_results++;
		if (want.kind == K_END)
			n_ends++;
		if (want.kind == K_LOWER || want.kind == K_UPPER)
			n_tiles++;
		if (kind !== want.kind)
			mismatch("kind", 32'(want.kind), 32'(kind));
		if (value !== want.value)
			mismatch("value", want.value, value);
		if (last !== want.layer_last)
			mismatch("layer_last", 32'(want.layer_last), 32'(last));
	endfunction
endclass

module tb_varint_chunk_map_parser_unit;
	localparam int TILE_BYTES  = 2;
	localparam int SIDE_BITS   = 12;
	localparam int SIDE_LIMIT  = (1 << SIDE_BITS) - 1;
	localparam int N_PHASES    = 7;
	localparam int PHASE_ITEMS = 230;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYC  = 8;
	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_LAYER   = 96;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;    // [7:0] data_byte
	logic               s_tuser;    // [0] first
	logic               m_tvalid;
	logic               m_tready;
	logic [VALUE_W-1:0] m_tdata;    // [31:0] value
	logic [KIND_W-1:0]  m_tuser;    // [2:0] kind
	logic               m_tlast;
	logic               cfg_we;
	logic [INDEX_W-1:0] cfg_index;
	logic [CODE_W-1:0]  cfg_data;

	map_scoreboard #(TILE_BYTES, SIDE_BITS) sb;

	bit first_pending;
	bit hold_request;
	int send_mode;
	int recv_mode;
	int n_sent;
	int cycle_count;

	// reset config: empty header, chipset with all ones, saturating height,
	// zero width so the lower layer is empty, repeated lower layer skipped,
	// type above 16 bits, end, ignored byte, restart straight into end
	logic [8:0] intro_bytes [29] = '{
		9'h000,
		9'h001, 9'h081, 9'h000, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F,
		9'h003, 9'h000, 9'h0A0, 9'h000,
		9'h002, 9'h000, 9'h000,
		9'h047, 9'h005,
		9'h047, 9'h001, 9'h0C3,
		9'h084, 9'h080, 9'h000, 9'h000,
		9'h000,
		9'h012,
		9'h100,
		9'h000
	};

	varint_chunk_map_parser_unit #(
		.TILE_BYTES(TILE_BYTES),
		.SIDE_BITS (SIDE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycle_count, sb.due_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.take_byte(s_tdata, s_tuser);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata, m_tlast);
		end
	end

	function automatic int draw_gap(int m);
		case (m)
			0: return 0;
			1: return $urandom_range(0, 17);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
		endcase
	endfunction

	// receiver: random stalls per word, one long hold-off on request
	initial begin
		int gap;
		int n;
		n = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (n % 40 == 0)
				recv_mode = $urandom_range(0, 2);
			n++;
			gap = draw_gap(recv_mode);
			if (hold_request) begin
				hold_request = 1'b0;
				gap = HOLD_CYCLES;
			end
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic push_byte(input logic [7:0] b);
		int gap;
		logic f;
		f = first_pending;
		first_pending = 1'b0;
		if (n_sent % 50 == 0)
			send_mode = $urandom_range(0, 2);
		n_sent++;
		gap = draw_gap(send_mode);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= f;
		do @(posedge clk); while (!s_tready);
	endtask

	// big-endian 7-bit groups, sometimes padded with zero groups or with
	// junk groups that shift out past bit 31
	task automatic push_varint(input logic [31:0] v);
		int need;
		int n;
		int i;
		logic [7:0] grp;
		need = 1;
		while (need < 5 && (v >> (7 * need)) != 0)
			need++;
		n = need;
		case ($urandom_range(0, 9))
			0, 1: n = need + $urandom_range(1, 2);
			2: n = 5 + $urandom_range(0, 1);
			default: ;
		endcase
		for (i = n - 1; i >= 0; i--) begin
			if (i < 4)
				grp = 8'(v >> (7 * i)) & DATA_MASK;
			else if (i == 4)
				grp = {1'b0, 3'($urandom_range(0, 7)), v[31:28]};
			else
				grp = 8'($urandom_range(0, 127));
			if (i > 0)
				grp = grp | CONT_MASK;
			push_byte(grp);
		end
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'd127;
			3: return 32'd128;
			4: return 32'd16384;
			5: return 32'd4096;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_side();
		case ($urandom_range(0, 9))
			7: return $urandom_range(6, 12);
			8: return pick_value();
			9: return $urandom_range(SIDE_LIMIT - 5, SIDE_LIMIT + 5);
			default: return $urandom_range(0, 5);
		endcase
	endfunction

	// one map file: header, random chunks, usually an end code and some
	// trailing junk; a layer too long to send in full gets cut off
	task automatic gen_file();
		int w;
		int h;
		int n;
		int k;
		int pick;
		int hdr;
		logic [31:0] t;
		logic [31:0] v;
		logic [31:0] sz;
		chunk_role_e role;
		bit lo_seen;
		bit up_seen;
		w = int'(sb.cfg.default_width);
		h = int'(sb.cfg.default_height);
		lo_seen = 1'b0;
		up_seen = 1'b0;
		first_pending = 1'b1;
		pick = $urandom_range(0, 49);
		hdr = (pick < 28) ? 0 : (pick < 49) ? $urandom_range(1, 4) : $urandom_range(100, 140);
		push_varint(hdr);
		repeat (hdr) push_byte(8'($urandom_range(0, 255)));
		for (k = $urandom_range(0, 8); k > 0; k--) begin
			if ($urandom_range(0, 39) == 0)
				push_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 99) == 0) begin
				first_pending = 1'b1;
				push_byte(8'($urandom_range(0, 255)));
			end
			pick = $urandom_range(0, 99);
			if (pick < 10)
				t = 32'(sb.cfg.chipset_code);
			else if (pick < 25)
				t = 32'(sb.cfg.width_code);
			else if (pick < 40)
				t = 32'(sb.cfg.height_code);
			else if (pick < 60)
				t = 32'(sb.cfg.lower_layer_code);
			else if (pick < 80)
				t = 32'(sb.cfg.upper_layer_code);
			else
				t = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 65535);
			role = sb.role_of(t);
			push_varint(t);
			if (role == R_END) begin
				repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
				return;
			end
			sz = $urandom_range(0, 6);
			case (role)
				R_CHIPSET, R_WIDTH, R_HEIGHT: begin
					push_varint(($urandom_range(0, 3) == 0) ? pick_value() : sz);
					v = (role == R_CHIPSET) ? pick_value() : pick_side();
					push_varint(v);
					if (role == R_WIDTH)
						w = (v > SIDE_LIMIT) ? SIDE_LIMIT : v;
					if (role == R_HEIGHT)
						h = (v > SIDE_LIMIT) ? SIDE_LIMIT : v;
				end
				R_LOWER, R_UPPER: begin
					if ((role == R_UPPER && !up_seen) || (role == R_LOWER && !lo_seen)) begin
						push_varint(($urandom_range(0, 3) == 0) ? pick_value() : sz);
						if (role == R_UPPER)
							up_seen = 1'b1;
						else
							lo_seen = 1'b1;
						n = w * h * TILE_BYTES;
						if (n > MAX_LAYER) begin
							repeat ($urandom_range(0, 40))
								push_byte(8'($urandom_range(0, 255)));
							return;
						end
						repeat (n) push_byte(8'($urandom_range(0, 255)));
					end else begin
						push_varint(sz);
						repeat (sz) push_byte(8'($urandom_range(0, 255)));
					end
				end
				default: begin
					push_varint(sz);
					repeat (sz) push_byte(8'($urandom_range(0, 255)));
				end
			endcase
		end
		if ($urandom_range(0, 9) < 8) begin
			push_varint(32'(sb.cfg.end_code));
			repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// wait for every predicted word, then give silent bytes time to finish
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_reg(input logic [INDEX_W-1:0] idx, input logic [CODE_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		sb.write_cfg(idx, val);
		@(posedge clk);
	endtask

	function automatic logic [CODE_W-1:0] rand_code();
		return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 15)) :
			16'($urandom_range(0, 65535));
	endfunction

	task automatic configure(input int phase);
		logic [CODE_W-1:0] vals [8];
		int i;
		case (phase)
			0: begin
				vals[REG_CHIPSET] = 16'd10;
				vals[REG_WIDTH]   = 16'd11;
				vals[REG_HEIGHT]  = 16'd12;
				vals[REG_LOWER]   = 16'd13;
				vals[REG_UPPER]   = 16'd14;
				vals[REG_END]     = 16'd15;
				vals[REG_DEF_WID] = 16'd1;
				vals[REG_DEF_HGT] = 16'd1;
			end
			1: begin
				vals[REG_CHIPSET] = 16'hFFFF;
				vals[REG_WIDTH]   = 16'h0000;
				vals[REG_HEIGHT]  = 16'h7FFF;
				vals[REG_LOWER]   = 16'h00FF;
				vals[REG_UPPER]   = 16'hFF00;
				vals[REG_END]     = 16'h8000;
				vals[REG_DEF_WID] = 16'(SIDE_LIMIT);
				vals[REG_DEF_HGT] = 16'(SIDE_LIMIT);
			end
			2: begin
				// overlapping codes: end beats chipset, width beats height,
				// upper beats lower
				vals[REG_CHIPSET] = 16'd5;
				vals[REG_END]     = 16'd5;
				vals[REG_WIDTH]   = 16'd6;
				vals[REG_HEIGHT]  = 16'd6;
				vals[REG_UPPER]   = 16'd7;
				vals[REG_LOWER]   = 16'd7;
				vals[REG_DEF_WID] = 16'd3;
				vals[REG_DEF_HGT] = 16'd2;
			end
			default: begin
				vals[REG_CHIPSET] = rand_code();
				vals[REG_WIDTH]   = rand_code();
				vals[REG_HEIGHT]  = rand_code();
				vals[REG_LOWER]   = rand_code();
				vals[REG_UPPER]   = rand_code();
				vals[REG_END]     = rand_code();
				vals[REG_DEF_WID] = ($urandom_range(0, 3) == 0) ?
					16'($urandom_range(1, SIDE_LIMIT)) : 16'($urandom_range(1, 6));
				vals[REG_DEF_HGT] = ($urandom_range(0, 3) == 0) ?
					16'($urandom_range(1, SIDE_LIMIT)) : 16'($urandom_range(1, 6));
			end
		endcase
		for (i = 0; i < 8; i++)
			set_reg(INDEX_W'(i), vals[i]);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int phase;
		int budget;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = 1'b0;
		m_tready      = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_CHIPSET;
		cfg_data      = '0;
		first_pending = 1'b0;
		hold_request  = 1'b0;
		send_mode     = 0;
		recv_mode     = 0;
		n_sent        = 0;
		cycle_count   = 0;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (intro_bytes[i]) begin
			first_pending = intro_bytes[i][8];
			push_byte(intro_bytes[i][7:0]);
		end
		settle();
		for (phase = 0; phase < N_PHASES; phase++) begin
			configure(phase);
			if (phase == 3) begin
				// receiver stops for a while, sender starts out at full rate
				hold_request = 1'b1;
				send_mode = 0;
			end
			budget = n_sent + PHASE_ITEMS;
			while (n_sent < budget)
				gen_file();
			settle();
		end
		$display("sent %0d bytes over %0d register settings incl. overlapping codes",
			sb.n_bytes, N_PHASES + 1);
		$display("checked %0d result words: %0d tile bytes, %0d end markers",
			sb.n_results, sb.n_tiles, sb.n_ends);
		if (sb.n_errors == 0 && sb.due_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
